// ----- hw/rtl/crc_checked_packet_receiver_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-checked packet receiver
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_PACKET_RECEIVER_UNIT_MACROS_SVH
`define CRC_CHECKED_PACKET_RECEIVER_UNIT_MACROS_SVH

// Implication checked in the next cycle, off while reset is asserted.
`define CPRX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cprx assertion failed");

// Implication checked in the same cycle, off while reset is asserted.
`define CPRX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cprx assertion failed");

// Condition that must hold in the cycle after reset is sampled.
`define CPRX_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("cprx reset assertion failed");

`endif

// ----- hw/rtl/cprx_pkg.sv -----
// ----------------------------------------------------------------------------
// cprx_pkg
// Shared constants, types and the CRC-16-CCITT byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cprx_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int CFG_IDX_W   = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd1;

  localparam logic [7:0]  PREFIX_RESET = 8'h00;
  localparam logic [7:0]  HEADER_RESET = 8'h81;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;

  // end-of-packet status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_BAD_HEADER = 3'd1;
  localparam logic [2:0] STAT_ZERO_LEN   = 3'd2;
  localparam logic [2:0] STAT_TOO_LONG   = 3'd3;
  localparam logic [2:0] STAT_CRC_BAD    = 3'd4;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           data;
  } cfg_wr_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] status;
  } result_t;

  // CRC-16-CCITT, polynomial 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
    logic [7:0] x;
    x = crc[15:8] ^ d;
    x = x ^ {4'h0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

// ----- hw/rtl/cprx_in_stage.sv -----
// ----------------------------------------------------------------------------
// cprx_in_stage
// Input register: captures one received byte and hands it to the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cprx_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  input  logic                  advance,
  output cprx_pkg::byte_stage_t stage
);
  import cprx_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] data_r;
  logic       in_fire;

  // take a new byte when empty or when the held one leaves this cycle
  assign in_ready = !vld_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_fire) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_r <= in_rx_byte;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.data = data_r;

endmodule

// ----- hw/rtl/cprx_deframer.sv -----
// ----------------------------------------------------------------------------
// cprx_deframer
// Framing state machine, length check, running CRC and the config registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cprx_deframer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cprx_pkg::cfg_wr_t     cfg_wr,
  input  cprx_pkg::byte_stage_t stage,
  input  logic                  step,
  output logic                  res_vld,
  output cprx_pkg::result_t     res
);
  import cprx_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LEN_LO  = 3'd1;
  localparam logic [2:0] S_LEN_HI  = 3'd2;
  localparam logic [2:0] S_PAYLOAD = 3'd3;
  localparam logic [2:0] S_CRC_LO  = 3'd4;
  localparam logic [2:0] S_CRC_HI  = 3'd5;

  logic [2:0]       state_r,  state_nxt;
  logic [7:0]       prefix_r, header_r;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0] len_r,    len_nxt;
  logic [LEN_W-1:0] cnt_r,    cnt_nxt;
  logic [15:0]      crc_r,    crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [15:0]      length16;
  logic [LEN_W-1:0] cnt_inc;
  logic [7:0]       b;

  assign b        = stage.data;
  assign length16 = {b, len_lo_r};
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    res_vld    = 1'b0;
    res        = '0;
    if (step) begin
      unique case (state_r)
        S_IDLE: begin
          priority if (b == prefix_r) begin
            state_nxt = S_IDLE;
          end else if (b != header_r) begin
            res_vld    = 1'b1;
            res.is_end = 1'b1;
            res.status = STAT_BAD_HEADER;
          end else begin
            state_nxt = S_LEN_LO;
          end
        end
        S_LEN_LO: begin
          len_lo_nxt = b;
          state_nxt  = S_LEN_HI;
        end
        S_LEN_HI: begin
          priority if (length16 == 16'h0000) begin
            res_vld    = 1'b1;
            res.is_end = 1'b1;
            res.status = STAT_ZERO_LEN;
            state_nxt  = S_IDLE;
          end else if (length16 > 16'(MAX_PAYLOAD)) begin
            res_vld    = 1'b1;
            res.is_end = 1'b1;
            res.status = STAT_TOO_LONG;
            state_nxt  = S_IDLE;
          end else begin
            len_nxt   = LEN_W'(length16);
            cnt_nxt   = '0;
            crc_nxt   = CRC_INIT;
            state_nxt = S_PAYLOAD;
          end
        end
        S_PAYLOAD: begin
          res_vld           = 1'b1;
          res.payload_byte  = b;
          res.payload_index = 8'(cnt_r);
          crc_nxt           = crc_update(crc_r, b);
          cnt_nxt           = cnt_inc;
          if (cnt_inc == len_r) begin
            state_nxt = S_CRC_LO;
          end
        end
        S_CRC_LO: begin
          crc_lo_nxt = b;
          state_nxt  = S_CRC_HI;
        end
        S_CRC_HI: begin
          res_vld    = 1'b1;
          res.is_end = 1'b1;
          res.status = ({b, crc_lo_r} == crc_r) ? STAT_OK : STAT_CRC_BAD;
          state_nxt  = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      crc_r    <= CRC_INIT;
      prefix_r <= PREFIX_RESET;
      header_r <= HEADER_RESET;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
      if (cfg_wr.en) begin
        unique case (cfg_wr.idx)
          REG_PREFIX: prefix_r <= cfg_wr.data;
          REG_HEADER: header_r <= cfg_wr.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    len_lo_r <= len_lo_nxt;
    len_r    <= len_nxt;
    cnt_r    <= cnt_nxt;
    crc_lo_r <= crc_lo_nxt;
  end

endmodule

// ----- hw/rtl/cprx_out_stage.sv -----
// ----------------------------------------------------------------------------
// cprx_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cprx_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld_vld,
  input  cprx_pkg::result_t ld_res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output cprx_pkg::result_t out_res
);
  import cprx_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  // free when empty or when the held result leaves this cycle
  assign can_load = !vld_r || out_ready;
  assign vld_nxt  = can_load ? ld_vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && ld_vld) begin
      res_r <= ld_res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ----- hw/rtl/crc_checked_packet_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// crc_checked_packet_receiver_unit
// Length-prefixed packet deframer with CRC-16-CCITT payload check.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received serial byte per transaction (in_valid / in_ready).
//   out_* : one result per transaction (out_valid / out_ready). A payload
//           byte comes with out_is_end = 0 and its index; a packet end comes
//           with out_is_end = 1 and out_status (ok, bad header, zero length,
//           too long, CRC mismatch). Prefix, header, CRC-low and, for an
//           accepted length, length bytes produce no result.
//   cfg_* : register writes (index 0 prefix byte, 1 header byte), always
//           ready; write only while no byte is in flight.
// Path: the framing and CRC logic sits between the input and result registers;
//   a byte's result is loaded when the result register can take it.
// Throughput: one byte per cycle while out_ready does not stall the result
//   register, set by the single-byte CRC update between the two registers.
// Reset: synchronous, active low; both stages empty, framing idle, prefix
//   0x00, header 0x81.
// Stall: a result waiting on out_ready holds; the input register still takes
//   one more byte if it is empty, then in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_checked_packet_receiver_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_end,
  output logic [7:0]                     out_payload_byte,
  output logic [7:0]                     out_payload_index,
  output logic [2:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cprx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import cprx_pkg::*;

  byte_stage_t stage;
  cfg_wr_t     cfg_wr;
  result_t     res;
  result_t     out_res;
  logic        res_vld;
  logic        can_load;
  logic        advance;

  // the config port never stalls
  assign cfg_ready  = 1'b1;
  assign cfg_wr.en  = cfg_valid;
  assign cfg_wr.idx = cfg_index;
  assign cfg_wr.data = cfg_data;

  // advance the held byte whenever the result register can take its result
  assign advance = stage.vld && can_load;

  cprx_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .stage      (stage)
  );

  // framing, length check and running CRC
  cprx_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .stage   (stage),
    .step    (advance),
    .res_vld (res_vld),
    .res     (res)
  );

  cprx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_vld    (res_vld),
    .ld_res    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_is_end        = out_res.is_end;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_status        = out_res.status;

endmodule

// ----- hw/rtl/cprx_checker.sv -----
// ----------------------------------------------------------------------------
// cprx_checker
// Port-level assertions for the packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc_checked_packet_receiver_unit_macros.svh"

module cprx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_end,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index,
  input logic [2:0] out_status
);
  import cprx_pkg::*;

  // a stalled result holds
  `CPRX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))

  // payload bytes carry a zero status
  `CPRX_ASSERT_NOW(a_payload_status, out_valid && !out_is_end, out_status == STAT_OK)

  // packet ends carry zero data and index, and a defined status code
  `CPRX_ASSERT_NOW(a_end_fields, out_valid && out_is_end, out_payload_byte == 8'h00 && out_payload_index == 8'h00 && (out_status == STAT_OK || out_status == STAT_BAD_HEADER || out_status == STAT_ZERO_LEN || out_status == STAT_TOO_LONG || out_status == STAT_CRC_BAD))

  // nothing comes out right after reset
  `CPRX_ASSERT_AFTER_RESET(a_reset_empty, !out_valid && in_ready)

endmodule

bind crc_checked_packet_receiver_unit cprx_checker u_cprx_checker (.*);

// ----- tb/crc_checked_packet_receiver_unit_scoreboard.sv -----
// ----------------------------------------------------------------------------
// crc_checked_packet_receiver_unit_scoreboard
// Watches the byte, result and register channels of the packet receiver,
// tracks the framing state and CRC-16-CCITT of the byte stream on its own,
// and compares every result transaction with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_checked_packet_receiver_unit_scoreboard
  import cprx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_is_end,
  input  logic [7:0]           out_payload_byte,
  input  logic [7:0]           out_payload_index,
  input  logic [2:0]           out_status,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);

  // register copies and framing state
  logic [7:0]  prefix_q;
  logic [7:0]  header_q;
  logic [8:0]  pos_q;      // 0 idle, 1/2 length, 3+k payload, then CRC low/high
  logic [15:0] len_q;
  logic [15:0] crc_q;
  logic [7:0]  crc_lo_q;

  result_t due_results[$];
  int      mism = 0;
  int      n_seen = 0;

  // bitwise CRC-16-CCITT, polynomial 0x1021, MSB first
  function automatic logic [15:0] ccitt_fold(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

  // advance the framing state by one received byte
  task automatic deframe_byte(input logic [7:0] b, output bit emit, output result_t r);
    logic [16:0] crc_lo_pos;
    crc_lo_pos = {1'b0, len_q} + 17'd3;
    emit = 1'b0;
    r    = '0;
    if (pos_q == 9'd0) begin
      if (b != prefix_q) begin
        if (b == header_q) begin
          pos_q = 9'd1;
        end else begin
          emit     = 1'b1;
          r.is_end = 1'b1;
          r.status = STAT_BAD_HEADER;
        end
      end
    end else if (pos_q == 9'd1) begin
      len_q = {8'h00, b};
      pos_q = 9'd2;
    end else if (pos_q == 9'd2) begin
      len_q = {b, len_q[7:0]};
      if (len_q == 16'd0) begin
        emit     = 1'b1;
        r.is_end = 1'b1;
        r.status = STAT_ZERO_LEN;
        pos_q    = 9'd0;
      end else if (len_q > 16'(MAX_PAYLOAD)) begin
        emit     = 1'b1;
        r.is_end = 1'b1;
        r.status = STAT_TOO_LONG;
        pos_q    = 9'd0;
      end else begin
        crc_q = CRC_INIT;
        pos_q = 9'd3;
      end
    end else if ({8'h00, pos_q} == crc_lo_pos) begin
      crc_lo_q = b;
      pos_q    = pos_q + 9'd1;
    end else if ({8'h00, pos_q} > crc_lo_pos) begin
      emit     = 1'b1;
      r.is_end = 1'b1;
      r.status = ({b, crc_lo_q} == crc_q) ? STAT_OK : STAT_CRC_BAD;
      pos_q    = 9'd0;
    end else begin
      emit            = 1'b1;
      r.payload_byte  = b;
      r.payload_index = 8'(pos_q - 9'd3);
      crc_q           = ccitt_fold(crc_q, b);
      pos_q           = pos_q + 9'd1;
    end
  endtask

  function automatic void report_mismatch(string what, result_t want, result_t got);
    mism++;
    if (mism <= 10) begin
      $display("%0t: %s: expected end=%0b byte=%02h idx=%0d status=%0d",
               $time, what, want.is_end, want.payload_byte, want.payload_index,
               want.status);
      $display("%0t: %s:   actual end=%0b byte=%02h idx=%0d status=%0d",
               $time, what, got.is_end, got.payload_byte, got.payload_index,
               got.status);
    end
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    bit      emit;
    if (!rst_n) begin
      prefix_q = PREFIX_RESET;
      header_q = HEADER_RESET;
      pos_q    = '0;
      len_q    = '0;
      crc_q    = CRC_INIT;
      crc_lo_q = '0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_is_end, out_payload_byte, out_payload_index, out_status};
        n_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("result with none due", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.is_end !== want.is_end || got.payload_byte !== want.payload_byte ||
              got.payload_index !== want.payload_index || got.status !== want.status) begin
            report_mismatch("field mismatch", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PREFIX: prefix_q = cfg_data;
          REG_HEADER: header_q = cfg_data;
        endcase
      end
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte, emit, want);
        if (emit) due_results.push_back(want);
      end
    end
    fail_count <= mism;
    pending    <= due_results.size();
    checked    <= n_seen;
  end

endmodule

// ----- tb/crc_checked_packet_receiver_unit_tb.sv -----
// ----------------------------------------------------------------------------
// crc_checked_packet_receiver_unit_tb
// Drives framed byte streams into the packet receiver under several prefix and
// header settings and handshake mixes; the scoreboard beside the block
// predicts and checks every result, this module only makes stimulus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_checked_packet_receiver_unit_tb;
  import cprx_pkg::*;

  localparam int LATENCY     = 1;       // from input register to result register
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int LIMIT       = 200000;  // watchdog, cycles

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_is_end;
  logic [7:0]           out_payload_byte;
  logic [7:0]           out_payload_index;
  logic [2:0]           out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int fail_count;
  int pending;
  int checked;

  // handshake mix of the current phase, percent of cycles
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // hold-off request from the stimulus, served by its own process
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;

  // register values as the stimulus sees them, for building packets
  logic [7:0] cur_prefix = PREFIX_RESET;
  logic [7:0] cur_header = HEADER_RESET;

  int n_sent     = 0;
  int n_settings = 1;
  int cycles     = 0;

  crc_checked_packet_receiver_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_end        (out_is_end),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  crc_checked_packet_receiver_unit_scoreboard u_scoreboard (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_end        (out_is_end),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: decide out_ready at every falling edge; a hold-off overrides
  // the random stalls.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_active && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Long hold-off: keep the result channel blocked for HOLD_CYCLES so the
  // block fills up and back-pressures the sender.
  initial begin
    forever begin
      wait (hold_req);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_active = 1'b0;
      hold_req    = 1'b0;
    end
  end

  // Watchdog: end the run if it never drains.
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

  // random byte that differs from the given one
  function automatic logic [7:0] other_byte(input logic [7:0] v);
    logic [7:0] r;
    r = 8'($urandom);
    while (r == v) r = 8'($urandom);
    return r;
  endfunction

  // Offer one byte: idle at random first, then hold valid and the byte until
  // the transaction completes at a rising edge.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Header and length; payload and CRC trailer only for an accepted length.
  // A negative fill draws random payload, else every byte is the fill value.
  task automatic send_packet(input int len, input bit corrupt, input int fill);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    send_byte(cur_header);
    send_byte(8'(len));
    send_byte(8'(len >> 8));
    if (len == 0 || len > MAX_PAYLOAD) return;
    for (int i = 0; i < len; i++) begin
      b   = (fill < 0) ? 8'($urandom) : 8'(fill);
      crc = crc_ccitt_step(crc, b);
      send_byte(b);
    end
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(15));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  // Pause the sender until every due result has come, then let the pipeline
  // empty of bytes that cause no result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write both registers with the block idle.
  task automatic set_config(input logic [7:0] pfx, input logic [7:0] hdr);
    drain();
    write_reg(REG_PREFIX, pfx);
    write_reg(REG_HEADER, hdr);
    cur_prefix = pfx;
    cur_header = hdr;
    n_settings++;
  endtask

  // Random traffic: mostly well-formed packets with random content, the rest
  // stray bytes, length errors and truncated packets.
  task automatic run_phase(input int target, input int idle_pct, input int stall_pct,
                           input bit with_max);
    int         start;
    int         kind;
    int         r;
    int         len;
    logic [7:0] b;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    start         = n_sent;
    if (with_max) send_packet(MAX_PAYLOAD, 1'b0, -1);
    while (n_sent - start < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        repeat ($urandom_range(3)) send_byte(cur_prefix);
        r   = $urandom_range(99);
        len = (r < 2) ? MAX_PAYLOAD : (r < 12) ? $urandom_range(64, 13) : $urandom_range(12, 1);
        send_packet(len, $urandom_range(3) == 0, -1);
      end else if (kind < 78) begin
        // stray byte while idle: neither filler nor header
        b = other_byte(cur_prefix);
        while (b == cur_header) b = other_byte(cur_prefix);
        send_byte(b);
      end else if (kind < 85) begin
        send_packet(0, 1'b0, -1);
      end else if (kind < 92) begin
        send_packet($urandom_range(65535, MAX_PAYLOAD + 1), 1'b0, -1);
      end else begin
        // truncated packet: the next bytes get swallowed as its remainder
        len = $urandom_range(12, 1);
        send_byte(cur_header);
        send_byte(8'(len));
        send_byte(8'h00);
        repeat ($urandom_range(len - 1)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] pfx;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = REG_PREFIX;
    cfg_data   = 8'h00;
    rst_n      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values, no idling.
    send_byte(PREFIX_RESET);              // filler while idle: skipped
    send_byte(8'hFF);                     // bad header
    send_packet(0, 1'b0, -1);             // zero length
    send_packet(MAX_PAYLOAD + 1, 1'b0, -1);  // one above the buffer
    send_packet(16'hFFFF, 1'b0, -1);      // largest length field
    send_packet(1, 1'b0, 8'h00);          // good CRC
    send_packet(1, 1'b1, 8'hFF);          // CRC mismatch

    // Block the result channel while the sender keeps pushing a packet.
    hold_req = 1'b1;
    send_packet(40, 1'b0, -1);
    drain();

    // Extreme register values, full rate, one largest packet.
    set_config(8'hFF, 8'h00);
    run_phase(400, 0, 0, 1'b1);

    set_config(8'h00, 8'hFF);
    run_phase(400, 67, 0, 1'b0);

    // Filler equal to header: the filler test wins, nothing can start.
    set_config(8'h7E, 8'h7E);
    send_byte(8'h7E);
    send_byte(8'h7E);
    send_byte(8'h00);
    send_byte(8'h81);

    pfx = 8'($urandom);
    set_config(pfx, other_byte(pfx));
    run_phase(400, 0, 67, 1'b1);

    pfx = 8'($urandom);
    set_config(pfx, other_byte(pfx));
    run_phase(400, 35, 35, 1'b0);

    drain();
    $display("Summary: %0d bytes under %0d register settings, four handshake mixes",
             n_sent, n_settings);
    $display("         and a long output hold-off; %0d results compared, %0d mismatches",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
